### hdl/acpe_pkg.sv
// Shared types, codes, tables and round functions of the AES-CBC PKCS#7 engine.
`timescale 1ns / 1ps
package acpe_pkg;

    localparam int BLK_W    = 128;
    localparam int RK_DEPTH = 30;
    localparam int RK_AW    = 5;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BLOCK = 2'd1,
        CMD_FINAL = 2'd2,
        CMD_NONE  = 2'd3
    } acpe_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_PAD   = 2'd1,
        STAT_NOKEY = 2'd2
    } acpe_status_t;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_KLEN   = 3'd4,
        REG_DECRYPT = 3'd5,
        REG_KEYRDY = 3'd6
    } acpe_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_KEYRD,
        S_INIT,
        S_ROUND,
        S_OUT
    } acpe_state_t;

    typedef struct packed {
        logic       capture;
        logic       exp_step;
        logic       exp_first;
        logic       exp_done;
        logic [5:0] exp_idx;
        logic       rk_rd;
        logic [3:0] rk_addr;
        logic       init;
        logic       round;
        logic       last;
        logic       out_load;
    } acpe_ctrl_t;

    typedef struct packed {
        logic       key_ready;
        logic       keys_valid;
        logic       decrypt;
        logic [3:0] nr;
    } acpe_dp_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] s, input int k);
        return s[BLK_W-1-8*k -: 8];
    endfunction

    function automatic logic [BLK_W-1:0] fwd_round(input logic [BLK_W-1:0] s,
                                                    input logic last);
        logic [7:0] t [16];
        logic [7:0] u [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [BLK_W-1:0] res;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = SBOX[get_byte(s, 4*((c+r)&3)+r)];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            u[4*c]   = last ? a0 : a0 ^ al ^ xt(a0 ^ a1);
            u[4*c+1] = last ? a1 : a1 ^ al ^ xt(a1 ^ a2);
            u[4*c+2] = last ? a2 : a2 ^ al ^ xt(a2 ^ a3);
            u[4*c+3] = last ? a3 : a3 ^ al ^ xt(a3 ^ a0);
        end
        for (int k = 0; k < 16; k++)
            res[BLK_W-1-8*k -: 8] = u[k];
        return res;
    endfunction

    function automatic logic [BLK_W-1:0] inv_round(input logic [BLK_W-1:0] s,
                                                    input logic [BLK_W-1:0] rk,
                                                    input logic last);
        logic [7:0] t [16];
        logic [7:0] u [16];
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [BLK_W-1:0] res;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*((c+r)&3)+r] = get_byte(s, 4*c+r);
        for (int k = 0; k < 16; k++)
            t[k] = INV_SBOX[t[k]] ^ get_byte(rk, k);
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                a[j]   = t[4*c+j];
                x2[j]  = xt(a[j]);
                x4[j]  = xt(x2[j]);
                x8[j]  = xt(x4[j]);
                m9[j]  = x8[j] ^ a[j];
                m11[j] = x8[j] ^ x2[j] ^ a[j];
                m13[j] = x8[j] ^ x4[j] ^ a[j];
                m14[j] = x8[j] ^ x4[j] ^ x2[j];
            end
            u[4*c]   = last ? a[0] : m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            u[4*c+1] = last ? a[1] : m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            u[4*c+2] = last ? a[2] : m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            u[4*c+3] = last ? a[3] : m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        for (int k = 0; k < 16; k++)
            res[BLK_W-1-8*k -: 8] = u[k];
        return res;
    endfunction

endpackage

### hdl/aes_cbc_pkcs7_engine_unit.sv
// Top level of the AES-CBC engine with PKCS#7 padding.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------
//  cfg      | in  | cfg_valid/ready    | cfg_index (register), cfg_data (value)
//  s (item) | in  | s_tvalid/tready    | tdata: block_high, block_low, tail_bytes; tuser: command
//  m (res)  | out | m_tvalid/tready    | tdata: out_high, out_low, out_bytes; tuser: status
//
// A cipher block passes round key read, initial key addition and nr rounds (nr = 10, 12 or 14),
// one AES round per cycle in the shared round unit; IV loads and rejected items skip the rounds.
// The first block after a key or key length write first runs key expansion of 4 * (nr + 1) words,
// one schedule word per cycle into the round key memory.
// Reset clears configuration, chaining value and the round key valid flag.
// A result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
module aes_cbc_pkcs7_engine_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // block_high, block_low, tail_bytes, zero fill
    input  logic [1:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // out_high, out_low, out_bytes, zero fill
    output logic [1:0]   m_tuser    // status
);
    import acpe_pkg::*;

    acpe_ctrl_t    ctrl;
    acpe_dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    acpe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_stat  (dp_stat),
        .ctrl     (ctrl)
    );

    acpe_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .ctrl      (ctrl),
        .dp_stat   (dp_stat)
    );

endmodule

### hdl/acpe_ctrl.sv
// Controller state machine: sequences key expansion, rounds and result hand-off.
`timescale 1ns / 1ps
module acpe_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_cmd,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  acpe_pkg::acpe_dp_stat_t dp_stat,
    output acpe_pkg::acpe_ctrl_t    ctrl
);
    import acpe_pkg::*;

    acpe_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    logic [3:0]  step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg & ~m_tready;
        ctrl        = '0;
        ctrl.exp_idx = cnt_reg;
        step        = cnt_reg[3:0];
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.capture = 1'b1;
                    cnt_next     = '0;
                    if ((s_cmd == CMD_BLOCK || s_cmd == CMD_FINAL) && dp_stat.key_ready)
                        state_next = dp_stat.keys_valid ? S_KEYRD : S_EXPAND;
                    else
                        state_next = S_OUT;
                end
            end
            S_EXPAND:
            begin
                ctrl.exp_step  = 1'b1;
                ctrl.exp_first = (cnt_reg == 6'd0);
                if (cnt_reg == {dp_stat.nr, 2'b11})
                begin
                    ctrl.exp_done = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_KEYRD;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_KEYRD:
            begin
                step       = 4'd0;
                ctrl.rk_rd = 1'b1;
                cnt_next   = 6'd1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                ctrl.init  = 1'b1;
                ctrl.rk_rd = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                ctrl.round = 1'b1;
                ctrl.last  = (cnt_reg[3:0] == dp_stat.nr);
                if (ctrl.last)
                    state_next = S_OUT;
                else
                begin
                    step       = cnt_reg[3:0] + 4'd1;
                    ctrl.rk_rd = 1'b1;
                    cnt_next   = cnt_reg + 6'd1;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ctrl.out_load = 1'b1;
                    ovalid_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ctrl.rk_addr = dp_stat.decrypt ? dp_stat.nr - step : step;
    end

endmodule

### hdl/acpe_datapath.sv
// Datapath: configuration, key schedule, round key memory, round unit, result register.
`timescale 1ns / 1ps
module acpe_datapath
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [2:0]              cfg_index,
    input  logic [63:0]             cfg_data,
    input  logic [135:0]            s_tdata,
    input  logic [1:0]              s_tuser,
    output logic [135:0]            m_tdata,
    output logic [1:0]              m_tuser,
    input  acpe_pkg::acpe_ctrl_t     ctrl,
    output acpe_pkg::acpe_dp_stat_t  dp_stat
);
    import acpe_pkg::*;

    logic [255:0]     key_reg;
    logic [1:0]       klen_reg;
    logic             decrypt_reg;
    logic             key_ready_reg;
    logic             rk_valid_reg;
    logic [BLK_W-1:0] cv_reg;

    logic [1:0]       cmd_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [3:0]       tail_reg;
    logic [BLK_W-1:0] st_reg;
    logic [63:0]      rk_hi_reg, rk_lo_reg;
    logic [31:0]      win_reg [8];
    logic [2:0]       kcnt_reg;
    logic [7:0]       rc_reg;
    logic [135:0]     out_data_reg;
    logic [1:0]       out_user_reg;

    logic [63:0]      rk_mem [RK_DEPTH];

    logic [3:0]       nk;
    logic [2:0]       kc;
    logic [7:0]       rcu;
    logic [31:0]      wprev, wnk, wt, wnew;
    logic [BLK_W-1:0] rk;
    logic [BLK_W-1:0] padded;
    logic [BLK_W-1:0] plain;
    logic [7:0]       pad;
    logic             bad;
    logic [BLK_W-1:0] stripped;
    logic [135:0]     res_data;
    logic [1:0]       res_user;
    logic [BLK_W-1:0] cv_next;

    assign nk = (klen_reg == 2'd0) ? 4'd4 : (klen_reg == 2'd1) ? 4'd6 : 4'd8;
    assign dp_stat.key_ready  = key_ready_reg;
    assign dp_stat.keys_valid = rk_valid_reg;
    assign dp_stat.decrypt    = decrypt_reg;
    assign dp_stat.nr         = nk + 4'd6;
    assign rk      = {rk_hi_reg, rk_lo_reg};
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            klen_reg      <= 2'd0;
            decrypt_reg   <= 1'b0;
            key_ready_reg <= 1'b0;
            rk_valid_reg  <= 1'b0;
            cv_reg        <= '0;
        end
        else
        begin
            if (ctrl.exp_done)
                rk_valid_reg <= 1'b1;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_KEY0:
                    begin
                        key_reg[255:192] <= cfg_data;
                        rk_valid_reg     <= 1'b0;
                    end
                    REG_KEY1:
                    begin
                        key_reg[191:128] <= cfg_data;
                        rk_valid_reg     <= 1'b0;
                    end
                    REG_KEY2:
                    begin
                        key_reg[127:64] <= cfg_data;
                        rk_valid_reg    <= 1'b0;
                    end
                    REG_KEY3:
                    begin
                        key_reg[63:0] <= cfg_data;
                        rk_valid_reg  <= 1'b0;
                    end
                    REG_KLEN:
                    begin
                        klen_reg     <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
                        rk_valid_reg <= 1'b0;
                    end
                    REG_DECRYPT: decrypt_reg   <= cfg_data[0];
                    REG_KEYRDY:  key_ready_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
            if (ctrl.out_load)
                cv_reg <= cv_next;
        end
    end

    // Key schedule: one word per cycle, window holds the last eight words
    always_comb
    begin
        kc    = ctrl.exp_first ? 3'd0 : kcnt_reg;
        rcu   = ctrl.exp_first ? 8'h01 : rc_reg;
        wprev = win_reg[0];
        wnk   = (nk == 4'd4) ? win_reg[3] : (nk == 4'd6) ? win_reg[5] : win_reg[7];
        if (kc == 3'd0)
            wt = sub_word({wprev[23:0], wprev[31:24]}) ^ {rcu, 24'h0};
        else if (nk == 4'd8 && kc == 3'd4)
            wt = sub_word(wprev);
        else
            wt = wprev;
        if (ctrl.exp_idx < 6'(nk))
            wnew = key_reg[255 - 32*ctrl.exp_idx[2:0] -: 32];
        else
            wnew = wnk ^ wt;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exp_step)
        begin
            win_reg[0] <= wnew;
            for (int k = 1; k < 8; k++)
                win_reg[k] <= win_reg[k-1];
            kcnt_reg <= (kc == 3'(nk - 4'd1)) ? 3'd0 : kc + 3'd1;
            if (kc == 3'd0 && ctrl.exp_idx >= 6'(nk))
                rc_reg <= xt(rcu);
            else
                rc_reg <= rcu;
            if (ctrl.exp_idx[0])
                rk_mem[ctrl.exp_idx[5:1]] <= {wprev, wnew};
        end
        if (ctrl.rk_rd)
        begin
            rk_hi_reg <= rk_mem[{ctrl.rk_addr, 1'b0}];
            rk_lo_reg <= rk_mem[{ctrl.rk_addr, 1'b1}];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            if (cmd_reg == CMD_FINAL && 5'(k) >= {1'b0, tail_reg})
                padded[BLK_W-1-8*k -: 8] = 8'(5'd16 - {1'b0, tail_reg});
            else
                padded[BLK_W-1-8*k -: 8] = get_byte(blk_reg, k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= s_tuser;
            blk_reg  <= {s_tdata[63:0], s_tdata[127:64]};
            tail_reg <= s_tdata[131:128];
        end
        if (ctrl.init)
            st_reg <= decrypt_reg ? blk_reg ^ rk : padded ^ cv_reg ^ rk;
        else if (ctrl.round)
            st_reg <= decrypt_reg ? inv_round(st_reg, rk, ctrl.last)
                                  : fwd_round(st_reg, ctrl.last) ^ rk;
        if (ctrl.out_load)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
    end

    // Result and chaining update
    always_comb
    begin
        plain = st_reg ^ cv_reg;
        pad   = plain[7:0];
        bad   = (pad == 8'd0) || (pad > 8'd16);
        for (int k = 0; k < 16; k++)
        begin
            if (9'(k) + {1'b0, pad} >= 9'd16)
            begin
                stripped[BLK_W-1-8*k -: 8] = 8'd0;
                if (get_byte(plain, k) != pad)
                    bad = 1'b1;
            end
            else
                stripped[BLK_W-1-8*k -: 8] = get_byte(plain, k);
        end
        res_data = '0;
        res_user = STAT_OK;
        cv_next  = cv_reg;
        if (cmd_reg == CMD_NONE)
            res_user = STAT_OK;
        else if (!key_ready_reg)
            res_user = STAT_NOKEY;
        else if (cmd_reg == CMD_LOAD)
            cv_next = blk_reg;
        else if (!decrypt_reg)
        begin
            res_data = {3'd0, 5'd16, st_reg[63:0], st_reg[127:64]};
            cv_next  = (cmd_reg == CMD_FINAL) ? '0 : st_reg;
        end
        else if (cmd_reg == CMD_BLOCK)
        begin
            res_data = {3'd0, 5'd16, plain[63:0], plain[127:64]};
            cv_next  = blk_reg;
        end
        else if (bad)
            res_user = STAT_PAD;
        else
        begin
            res_data = {3'd0, 5'(9'd16 - {1'b0, pad}), stripped[63:0], stripped[127:64]};
            cv_next  = '0;
        end
    end

endmodule

### hdl/acpe_checker.sv
// Port-level checks of the AES-CBC engine, bound to the top level.
`timescale 1ns / 1ps
module acpe_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import acpe_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[132:128] <= 5'd16 && m_tuser != 2'd3)
        else $error("byte count or status out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_PAD || m_tuser == STAT_NOKEY) |-> m_tdata == '0)
        else $error("error result carries data");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted item not held");

endmodule

bind aes_cbc_pkcs7_engine_unit acpe_checker u_acpe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### test/tb_aes_cbc_pkcs7_engine_unit.sv
// Self-checking testbench for the AES-CBC PKCS#7 engine: directed and random CBC runs.
`timescale 1ns / 1ps
module tb_aes_cbc_pkcs7_engine_unit;
    import acpe_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        bit [63:0] hi;
        bit [63:0] lo;
        bit [4:0]  nbytes;
        bit [1:0]  status;
    } cbc_result_t;

    class cbc_tracker;
        bit [63:0]   key_w [4];
        bit [1:0]    klen;
        bit          dec;
        bit          kready;
        bit [127:0]  cv;
        bit [31:0]   rk [60];
        bit [7:0]    fwd [256];
        bit [7:0]    rev [256];
        cbc_result_t expected [$];
        int          errors;

        function new();
            bit [7:0] x;
            bit [7:0] y;
            for (int i = 0; i < 256; i++)
            begin
                x = 0;
                for (int j = 1; j < 256; j++)
                    if (gm(i, j) == 8'h01)
                        x = j;
                y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                    ^ {x[3:0], x[7:4]} ^ 8'h63;
                fwd[i] = y;
                rev[y] = i;
            end
            errors = 0;
        endfunction

        function bit [7:0] gm(bit [7:0] a, bit [7:0] b);
            bit [7:0] r;
            r = 0;
            for (int i = 0; i < 8; i++)
            begin
                if (b[0])
                    r ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
                b = b >> 1;
            end
            return r;
        endfunction

        function void set_reg(acpe_reg_t idx, bit [63:0] v);
            case (idx)
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_w[idx] = v;
                REG_KLEN: klen = (v[1:0] == 2'd3) ? 2'd2 : v[1:0];
                REG_DECRYPT: dec = v[0];
                REG_KEYRDY: kready = v[0];
                default: ;
            endcase
        endfunction

        function int nk();
            return (klen == 0) ? 4 : (klen == 1) ? 6 : 8;
        endfunction

        function void expand();
            int n;
            bit [31:0] t;
            bit [7:0] rc;
            n = nk();
            rc = 1;
            for (int i = 0; i < n; i++)
                rk[i] = i[0] ? key_w[i >> 1][31:0] : key_w[i >> 1][63:32];
            for (int i = n; i < 4 * (n + 7); i++)
            begin
                t = rk[i - 1];
                if (i % n == 0)
                begin
                    t = {t[23:0], t[31:24]};
                    t = {fwd[t[31:24]], fwd[t[23:16]], fwd[t[15:8]], fwd[t[7:0]]};
                    t[31:24] ^= rc;
                    rc = gm(rc, 8'h02);
                end
                else if (n > 6 && i % n == 4)
                    t = {fwd[t[31:24]], fwd[t[23:16]], fwd[t[15:8]], fwd[t[7:0]]};
                rk[i] = rk[i - n] ^ t;
            end
        endfunction

        function bit [127:0] cipher(bit [127:0] blk, bit inv);
            bit [7:0] s [16];
            bit [7:0] t [16];
            bit [7:0] a [4];
            int nr;
            int rd;
            expand();
            nr = nk() + 6;
            for (int k = 0; k < 16; k++)
                s[k] = blk[127 - 8 * k -: 8];
            rd = inv ? nr : 0;
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4 * c + r] ^= rk[4 * rd + c][31 - 8 * r -: 8];
            for (int step = 1; step <= nr; step++)
            begin
                rd = inv ? nr - step : step;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        if (inv)
                            t[4 * ((c + r) & 3) + r] = rev[s[4 * c + r]];
                        else
                            t[4 * c + r] = fwd[s[4 * ((c + r) & 3) + r]];
                if (!inv && rd != nr)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int j = 0; j < 4; j++)
                            a[j] = t[4 * c + j];
                        for (int j = 0; j < 4; j++)
                            t[4 * c + j] = gm(a[j], 2) ^ gm(a[(j + 1) & 3], 3)
                                ^ a[(j + 2) & 3] ^ a[(j + 3) & 3];
                    end
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4 * c + r] ^= rk[4 * rd + c][31 - 8 * r -: 8];
                if (inv && rd != 0)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int j = 0; j < 4; j++)
                            a[j] = t[4 * c + j];
                        for (int j = 0; j < 4; j++)
                            t[4 * c + j] = gm(a[j], 14) ^ gm(a[(j + 1) & 3], 11)
                                ^ gm(a[(j + 2) & 3], 13) ^ gm(a[(j + 3) & 3], 9);
                    end
                s = t;
            end
            for (int k = 0; k < 16; k++)
                blk[127 - 8 * k -: 8] = s[k];
            return blk;
        endfunction

        function void note_item(acpe_cmd_t cmd, bit [63:0] hi, bit [63:0] lo, bit [3:0] tail);
            cbc_result_t res;
            bit [127:0] b;
            bit [7:0] pad;
            bit bad;
            res = '{0, 0, 0, STAT_OK};
            b = {hi, lo};
            if (cmd == CMD_NONE)
                ;
            else if (!kready)
                res.status = STAT_NOKEY;
            else if (cmd == CMD_LOAD)
                cv = b;
            else if (!dec)
            begin
                if (cmd == CMD_FINAL)
                    for (int i = tail; i < 16; i++)
                        b[127 - 8 * i -: 8] = 16 - tail;
                b = cipher(b ^ cv, 0);
                {res.hi, res.lo} = b;
                res.nbytes = 16;
                cv = (cmd == CMD_FINAL) ? '0 : b;
            end
            else
            begin
                b = cipher(b, 1) ^ cv;
                if (cmd == CMD_BLOCK)
                begin
                    {res.hi, res.lo} = b;
                    res.nbytes = 16;
                    cv = {hi, lo};
                end
                else
                begin
                    pad = b[7:0];
                    bad = (pad == 0 || pad > 16);
                    if (!bad)
                        for (int i = 16 - pad; i < 16; i++)
                            if (b[127 - 8 * i -: 8] != pad)
                                bad = 1;
                    if (bad)
                        res.status = STAT_PAD;
                    else
                    begin
                        res.nbytes = 16 - pad;
                        for (int i = 16 - pad; i < 16; i++)
                            b[127 - 8 * i -: 8] = 0;
                        {res.hi, res.lo} = b;
                        cv = '0;
                    end
                end
            end
            expected.push_back(res);
        endfunction

        function void check_result(bit [63:0] hi, bit [63:0] lo, bit [4:0] nb, bit [1:0] st);
            cbc_result_t e;
            if (expected.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual %h %h %0d %0d",
                         $time, hi, lo, nb, st);
                errors++;
                return;
            end
            e = expected.pop_front();
            if (e.hi != hi)
            begin
                $display("%0t out_high: expected %h actual %h", $time, e.hi, hi);
                errors++;
            end
            if (e.lo != lo)
            begin
                $display("%0t out_low: expected %h actual %h", $time, e.lo, lo);
                errors++;
            end
            if (e.nbytes != nb)
            begin
                $display("%0t out_bytes: expected %0d actual %0d", $time, e.nbytes, nb);
                errors++;
            end
            if (e.status != st)
            begin
                $display("%0t status: expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;

    cbc_tracker sb;
    cbc_tracker gen;
    int idle_mode;
    bit hold_req;
    int hold_left;
    int quiet;

    aes_cbc_pkcs7_engine_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    function bit sender_idle();
        return (idle_mode == 1 && $urandom_range(99) < 58) ||
               (idle_mode == 3 && $urandom_range(99) < 24);
    endfunction

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !((idle_mode == 2 && $urandom_range(99) < 58) ||
                          (idle_mode == 3 && $urandom_range(99) < 24));
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[63:0], m_tdata[127:64], m_tdata[132:128], m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet > QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(acpe_cmd_t cmd, bit [63:0] hi, bit [63:0] lo, bit [3:0] tail);
        gen.note_item(cmd, hi, lo, tail);
        gen.expected.delete();
        if (sender_idle())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while (sender_idle())
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, tail, lo, hi};
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(cmd, hi, lo, tail);
        @(negedge clk);
    endtask

    task automatic write_reg(acpe_reg_t idx, bit [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, v);
        gen.set_reg(idx, v);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // drain first, then rewrite every register
    task automatic configure(bit [1:0] klen, bit dec, bit kready, int key_kind);
        bit [63:0] k;
        drain();
        for (int i = 0; i < 4; i++)
        begin
            k = (key_kind == 0) ? 64'd0 : (key_kind == 1) ? '1 : {$urandom, $urandom};
            write_reg(acpe_reg_t'(i), k);
        end
        write_reg(REG_KLEN, klen);
        write_reg(REG_DECRYPT, dec);
        write_reg(REG_KEYRDY, kready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // pad 1..16 gives correct padding unless corrupt is set with pad 2..16; other pad values are invalid
    task automatic send_dec_final(bit [7:0] pad, bit corrupt);
        bit [127:0] p;
        p = {$urandom, $urandom, $urandom, $urandom};
        if (pad >= 1 && pad <= 16)
            for (int i = 16 - pad; i < 16; i++)
                p[127 - 8 * i -: 8] = pad;
        p[7:0] = pad;
        if (corrupt && pad >= 2)
            p[127 - 8 * (16 - pad) -: 8] ^= 8'h01 << $urandom_range(7);
        p = gen.cipher(p ^ gen.cv, 0);
        send_item(CMD_FINAL, p[127:64], p[63:0], $urandom_range(15));
    endtask

    task automatic run_message();
        int n;
        send_item(CMD_LOAD, {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(15));
        n = $urandom_range(3);
        repeat (n)
            send_item(CMD_BLOCK, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom_range(15));
        if (gen.dec && $urandom_range(99) < 85)
            send_dec_final($urandom_range(1, 16), 0);
        else
            send_item(CMD_FINAL, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom_range(15));
        if ($urandom_range(99) < 10)
            send_item(acpe_cmd_t'($urandom_range(3)), {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom_range(15));
    endtask

    task automatic run_messages(int count);
        repeat (count) run_message();
    endtask

    initial
    begin
        sb = new();
        gen = new();
        clk = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        idle_mode = 0;
        hold_req = 0;
        hold_left = 0;
        quiet = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // items before any key is marked ready
        send_item(CMD_LOAD, '1, '1, 4'hf);
        send_item(CMD_BLOCK, '0, '0, 4'h0);
        send_item(CMD_FINAL, '1, '0, 4'h5);
        send_item(CMD_NONE, '1, '1, 4'hf);

        configure(2'd0, 0, 1, 0);
        send_item(CMD_LOAD, '0, '0, 0);
        send_item(CMD_BLOCK, '0, '0, 0);
        send_item(CMD_BLOCK, '1, '1, 4'hf);
        send_item(CMD_FINAL, '1, '1, 4'h0);
        send_item(CMD_LOAD, '1, '1, 4'hf);
        send_item(CMD_FINAL, '1, '1, 4'hf);
        send_item(CMD_NONE, '1, '1, 4'hf);
        send_item(CMD_FINAL, 64'h0123456789abcdef, 64'hfedcba9876543210, 4'h8);
        run_messages(8);

        configure(2'd0, 1, 1, 0);
        send_item(CMD_LOAD, '1, '0, 4'h3);
        send_dec_final(8'd16, 0);
        send_dec_final(8'd1, 0);
        send_dec_final(8'd0, 0);
        send_dec_final(8'd17, 0);
        send_dec_final(8'd255, 0);
        send_dec_final(8'd4, 1);
        send_dec_final(8'd16, 1);
        send_item(CMD_BLOCK, '0, '0, 4'hf);
        send_item(CMD_NONE, '0, '0, 0);
        run_messages(8);

        configure(2'd1, 0, 0, 2);
        repeat (12)
            send_item(acpe_cmd_t'($urandom_range(3)), {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom_range(15));

        idle_mode = 1;
        configure(2'd1, 0, 1, 2);
        run_messages(12);
        idle_mode = 2;
        configure(2'd1, 1, 1, 2);
        run_messages(12);
        idle_mode = 3;
        configure(2'd2, 0, 1, 1);
        run_messages(12);

        idle_mode = 0;
        configure(2'd3, 1, 1, 2);
        hold_req = 1;
        run_messages(12);
        idle_mode = 3;
        configure(2'd2, 1, 1, 2);
        run_messages(12);
        idle_mode = 1;
        configure(2'd0, 0, 1, 2);
        run_messages(12);
        idle_mode = 2;
        configure(2'd2, 1, 1, 1);
        run_messages(12);
        idle_mode = 0;
        configure(2'd1, 1, 1, 0);
        run_messages(12);

        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
